@@ rtl/core/bit_stuff_gray_psk_mapper_core_assert.svh @@
// Assertion macros for the bit stuffing Gray 32-PSK mapper.
// Included by the RTL modules that check their own logic; no dependencies.
`ifndef BIT_STUFF_GRAY_PSK_MAPPER_CORE_ASSERT_SVH
`define BIT_STUFF_GRAY_PSK_MAPPER_CORE_ASSERT_SVH

`ifndef SYNTH

// Check that the consequent holds in the same cycle as the antecedent.
`define BSGP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define BSGP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BSGP_ASSERT_SAME(lbl, ante, cons, msg)
`define BSGP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/core/bsgp_pkg.sv @@
// Shared types and constants for the bit stuffing Gray 32-PSK mapper.
// No dependencies; imported by bsgp_stuffer and the top level.
`default_nettype none

package bsgp_pkg;

  localparam int unsigned SymBits = 5;
  localparam int unsigned ByteBits = 8;

  typedef logic [SymBits-1:0] phase_t;

  typedef struct packed {
    logic   vld;
    phase_t phase;
    logic   padded;
  } sym_evt_t;

  typedef struct packed {
    phase_t phase;
    logic   padded;
  } sym_ent_t;

  function automatic phase_t gray_decode(input phase_t g);
    phase_t b;
    b[SymBits-1] = g[SymBits-1];
    for (int i = SymBits - 2; i >= 0; i--) begin
      b[i] = b[i+1] ^ g[i];
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bsgp_stuffer.sv @@
// Bit-serial zero stuffer and 5-bit symbol assembler, one bit per cycle.
// Depends on bsgp_pkg and bit_stuff_gray_psk_mapper_core_assert.svh.
`default_nettype none

module bsgp_stuffer (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [7:0]          din,
  input  wire logic                last_in,
  output bsgp_pkg::sym_evt_t       evt,
  output logic                     done
);
  import bsgp_pkg::*;

  `include "bit_stuff_gray_psk_mapper_core_assert.svh"

  logic [7:0] shreg;
  logic [3:0] nbits;
  logic       stuff_pend;
  logic [2:0] run;
  logic [3:0] sym;
  logic [2:0] cnt;
  logic       last_r;
  logic       busy;
  logic       bit_in;

  assign bit_in = stuff_pend ? 1'b0 : shreg[7];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      stuff_pend <= 1'b0;
      run        <= '0;
      sym        <= '0;
      cnt        <= '0;
      evt        <= '0;
      done       <= 1'b0;
      last_r     <= 1'b0;
      nbits      <= '0;
    end else begin
      evt.vld <= 1'b0;
      done    <= 1'b0;
      if (start) begin
        shreg  <= din;
        nbits  <= 4'(ByteBits);
        last_r <= last_in;
        busy   <= 1'b1;
      end else if (busy) begin
        if (stuff_pend || nbits != 4'd0) begin
          // push one bit into the symbol
          if (cnt == 3'(SymBits - 1)) begin
            evt.vld    <= 1'b1;
            evt.phase  <= gray_decode({sym, bit_in});
            evt.padded <= 1'b0;
            sym        <= '0;
            cnt        <= '0;
          end else begin
            sym <= {sym[2:0], bit_in};
            cnt <= cnt + 3'd1;
          end
          if (stuff_pend) begin
            stuff_pend <= 1'b0;
          end else begin
            shreg <= {shreg[6:0], 1'b0};
            nbits <= nbits - 4'd1;
            if (bit_in) begin
              if (run == 3'(SymBits - 1)) begin
                run        <= '0;
                stuff_pend <= 1'b1;
              end else begin
                run <= run + 3'd1;
              end
            end else begin
              run <= '0;
            end
          end
        end else begin
          // close the byte; flush leftovers on the packet end
          if (last_r) begin
            if (cnt != 3'd0) begin
              evt.vld    <= 1'b1;
              evt.phase  <= gray_decode({1'b0, sym});
              evt.padded <= 1'b1;
            end
            sym <= '0;
            cnt <= '0;
            run <= '0;
          end
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

  `BSGP_ASSERT_SAME(a_start_idle, start, !busy, "start while busy")
  `BSGP_ASSERT_SAME(a_cnt_range, 1'b1, cnt < 3'(SymBits), "symbol fill out of range")
  `BSGP_ASSERT_NEXT(a_stuff_after_run, busy && !stuff_pend && nbits != 4'd0 && bit_in
                    && run == 3'(SymBits - 1), stuff_pend, "missing stuffed zero")
  `BSGP_ASSERT_SAME(a_done_idle, done, !busy, "done while busy")

endmodule

`default_nettype wire

@@ rtl/core/bit_stuff_gray_psk_mapper_core.sv @@
// Bit stuffer with Gray 32-PSK mapping: 8 to 10 stuffed bits plus a closing step per byte,
// then one result per cycle, while m_tready allows, out of a three-entry queue into m_tdata.
// The serial shift register moves one stuffed bit per cycle, and each byte drains one to three
// results; a new byte is accepted only in idle, once the results of the last have drained.
// Synchronous reset clears run, fill, queue and handshake state; no clearing pass.
`default_nettype none

module bit_stuff_gray_psk_mapper_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] data_byte
  input  wire logic       s_tlast,   // last_byte
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [4:0] phase_index, [7:5] zero
  output logic            m_tuser,   // padded
  output logic            m_tlast    // last_of_item
);
  import bsgp_pkg::*;

  `include "bit_stuff_gray_psk_mapper_core_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t     state;
  sym_evt_t   evt;
  logic       done;
  logic       start;
  sym_ent_t   q [0:2];
  logic [1:0] qcount;
  logic       out_free;

  assign start    = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);

  bsgp_stuffer u_stuffer (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .din     (s_tdata),
    .last_in (s_tlast),
    .evt     (evt),
    .done    (done)
  );

  always_ff @(posedge clk) begin
    if (evt.vld) begin
      q[qcount] <= '{phase: evt.phase, padded: evt.padded};
    end else if (state == ST_DRAIN && out_free) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      qcount   <= '0;
      m_tvalid <= 1'b0;
      m_tdata  <= '0;
      m_tuser  <= 1'b0;
      m_tlast  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (evt.vld) begin
            qcount <= qcount + 2'd1;
          end
          if (done) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, q[0].phase};
            m_tuser  <= q[0].padded;
            m_tlast  <= (qcount == 2'd1);
            qcount   <= qcount - 2'd1;
            if (qcount == 2'd1) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `BSGP_ASSERT_SAME(a_idle_empty, s_tready, qcount == 2'd0, "queue not empty in idle")
  `BSGP_ASSERT_SAME(a_evt_run, evt.vld, state == ST_RUN, "symbol outside run phase")
  `BSGP_ASSERT_SAME(a_pad_last, m_tvalid && m_tuser, m_tlast, "padded symbol not last")
  `BSGP_ASSERT_NEXT(a_done_drain, done, state == ST_DRAIN && qcount != 2'd0,
                    "byte closed with no symbol")

endmodule

`default_nettype wire
